>>> rtl/lifs_pkg.sv
// Shared types and constants for the linear interpolation frame stretcher.
// Used by lifs_ctrl, lifs_datapath and linear_interp_frame_stretch.
package lifs_pkg;

  localparam int COUNT_W    = 11;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = COUNT_W + FRAC_W;
  localparam int SAMPLE_W   = 8;
  localparam int INDEX_W    = 10;
  localparam int POS_W      = 32;
  localparam int IPART_W    = POS_W - FRAC_W;
  localparam int CFG_ADDR_W = 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(2);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_COUNT = 2'd1,
    STATUS_INDEX = 2'd2
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IN_COUNT  = 1'b0,
    CFG_OUT_COUNT = 1'b1
  } cfg_addr_t;

  typedef enum logic [2:0] {
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic div_init;
    logic div_run;
    logic fetch_start;
    logic load_write;
    logic read_mem;
    logic mult;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/lifs_ctrl.sv
// Controller state machine: step division after reset and configuration,
// load and fetch sequencing. Depends on lifs_pkg.
module lifs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   opcode,
  input  logic                   cfg_we,
  input  lifs_pkg::dp_status_t   st,
  output logic                   in_stall,
  output lifs_pkg::ctrl_cmd_t    cmd
);
  import lifs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DIV_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_run = 1'b1;
        if (st.div_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (opcode == OP_FETCH) begin
            cmd.fetch_start = 1'b1;
            state_next      = ST_READ;
          end else begin
            cmd.load_write = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.read_mem = 1'b1;
        state_next   = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      state_next = ST_DIV_INIT;
    end
  end

endmodule

>>> rtl/lifs_datapath.sv
// Datapath: count registers, step divider, frame store, position multiply,
// interpolation and output register. Depends on lifs_pkg.
module lifs_datapath #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lifs_pkg::ctrl_cmd_t               cmd,
  output lifs_pkg::dp_status_t              st,
  input  logic                              cfg_we,
  input  logic [lifs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lifs_pkg::COUNT_W-1:0]      cfg_data,
  input  logic [lifs_pkg::SAMPLE_W-1:0]     sample_in,
  input  logic [lifs_pkg::INDEX_W-1:0]      index,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [lifs_pkg::SAMPLE_W-1:0]     sample_out,
  output logic [1:0]                        status
);
  import lifs_pkg::*;

  localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int PROD_W = SAMPLE_W + FRAC_W + 2;

  logic [COUNT_W-1:0]   in_count;
  logic [COUNT_W-1:0]   out_count;
  logic [COUNT_W-1:0]   eff_n;
  logic [COUNT_W-1:0]   n_m1;
  logic [COUNT_W-1:0]   out_m1;
  logic                 err_count;

  logic [NUM_W-1:0]     quo;
  logic [COUNT_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [COUNT_W:0]     trial;
  logic                 trial_ge;

  logic [SAMPLE_W-1:0]  mem [MAX_SAMPLES];
  logic [AW-1:0]        addr_a;
  logic [AW-1:0]        addr_b;
  logic [SAMPLE_W-1:0]  a_r;
  logic [SAMPLE_W-1:0]  b_r;

  logic [INDEX_W+NUM_W-1:0] pos_full;
  logic [POS_W-1:0]     pos_r;
  logic [IPART_W-1:0]   ipart;
  logic                 last_j_r;
  logic                 last_sel;
  logic                 last_r;
  status_t              stat_r;
  logic [FRAC_W-1:0]    frac_r;

  logic signed [SAMPLE_W:0]          diff;
  logic signed [PROD_W-1:0]          prod_r;
  logic [SAMPLE_W-1:0]               interp;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= COUNT_RESET;
      out_count <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IN_COUNT:  in_count  <= cfg_data;
        CFG_OUT_COUNT: out_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_n     = (32'(in_count) > MAX_SAMPLES) ? COUNT_W'(MAX_SAMPLES) : in_count;
  assign n_m1      = eff_n - COUNT_W'(1);
  assign out_m1    = out_count - COUNT_W'(1);
  assign err_count = (eff_n < COUNT_MIN) || (out_count < COUNT_MIN);

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem, quo[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, out_m1};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo     <= {n_m1, {FRAC_W{1'b0}}};
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      rem     <= trial_ge ? COUNT_W'(trial - {1'b0, out_m1}) : COUNT_W'(trial);
      quo     <= {quo[NUM_W-2:0], trial_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  assign st.div_done = cmd.div_run && (div_cnt == DIV_CNT_W'(NUM_W - 1));
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_write && (32'(index) < MAX_SAMPLES)) begin
      mem[AW'(index)] <= sample_in;
    end
  end

  assign pos_full = {{NUM_W{1'b0}}, index} * {{INDEX_W{1'b0}}, quo};

  always_ff @(posedge clk) begin
    if (cmd.fetch_start) begin
      pos_r    <= pos_full[POS_W-1:0];
      last_j_r <= ({1'b0, index} == out_m1);
      if (err_count) begin
        stat_r <= STATUS_COUNT;
      end else if ({1'b0, index} >= out_count) begin
        stat_r <= STATUS_INDEX;
      end else begin
        stat_r <= STATUS_OK;
      end
    end
  end

  assign ipart    = pos_r[POS_W-1:FRAC_W];
  assign last_sel = last_j_r || (ipart >= IPART_W'(n_m1));
  assign addr_a   = last_sel ? AW'(n_m1) : ipart[AW-1:0];
  assign addr_b   = ipart[AW-1:0] + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.read_mem) begin
      a_r    <= mem[addr_a];
      b_r    <= mem[addr_b];
      last_r <= last_sel;
      frac_r <= pos_r[FRAC_W-1:0];
    end
  end

  assign diff = $signed({1'b0, b_r}) - $signed({1'b0, a_r});

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_r <= PROD_W'(diff) * PROD_W'($signed({1'b0, frac_r}));
    end
  end

  // floor shift of the product, then add the left sample
  assign interp = a_r + prod_r[FRAC_W+SAMPLE_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= stat_r;
      if (stat_r != STATUS_OK) begin
        sample_out <= '0;
      end else if (last_r) begin
        sample_out <= a_r;
      end else begin
        sample_out <= interp;
      end
    end
  end

endmodule

>>> rtl/linear_interp_frame_stretch.sv
// Top level of the linear interpolation frame stretcher.
// Instantiates lifs_ctrl and lifs_datapath; depends on lifs_pkg.
//
// A load transaction writes one sample into the frame store as it is taken.
// A fetch transaction returns one 8-bit unsigned linearly interpolated sample
// at a 16.16 position through the registered steps position multiply, two-port
// frame-store read, difference multiply and output register; the last waits
// while the previous result is still stalled at the output, and the next
// transaction is taken once the fetch has moved its result into the output
// register. After reset and after every configuration write the step is
// recomputed by a one-bit-per-cycle divider that holds off all transactions.
module linear_interp_frame_stretch #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [lifs_pkg::SAMPLE_W-1:0]     sample_in,
  input  logic [lifs_pkg::INDEX_W-1:0]      index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lifs_pkg::SAMPLE_W-1:0]     sample_out,
  output logic [1:0]                        status,
  input  logic                              cfg_we,
  input  logic [lifs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lifs_pkg::COUNT_W-1:0]      cfg_data
);
  import lifs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  lifs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .cfg_we   (cfg_we),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  lifs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .index      (index),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sample_out (sample_out),
    .status     (status)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_OK)) |-> (sample_out == '0))
    else $error("error result carries nonzero sample");

  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall)
    else $error("transaction taken during step recompute");

  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (opcode == OP_FETCH)) |=> in_stall)
    else $error("transaction taken while fetch in flight");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for linear_interp_frame_stretch: loads frames, stretches
// them through many in/out count settings and checks every fetch result against
// an in-bench interpolation model. Depends on lifs_pkg and the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lifs_pkg::*;

  typedef struct packed {
    opcode_t          op;
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  idx;
  } feed_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    status_t             status;
  } stretch_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = 1'b0;
  logic [SAMPLE_W-1:0]   sample_in = '0;
  logic [INDEX_W-1:0]    index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   sample_out;
  logic [1:0]            status;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [COUNT_W-1:0]    cfg_data = '0;

  linear_interp_frame_stretch i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .sample_in  (sample_in),
    .index      (index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Interpolation model state, updated on accepted transactions and writes
  logic [SAMPLE_W-1:0] frame_shadow [1024];
  logic [COUNT_W-1:0]  cur_in_count  = COUNT_RESET;
  logic [COUNT_W-1:0]  cur_out_count = COUNT_RESET;
  logic [31:0]         cur_step      = 32'h0001_0000;

  feed_item_t      feed_q [$];
  stretch_result_t fetch_results_q [$];
  int              errors = 0;

  // Stimulus-side view of the configuration and of which slots hold data
  logic [COUNT_W-1:0] gen_in  = COUNT_RESET;
  logic [COUNT_W-1:0] gen_out = COUNT_RESET;
  bit                 gen_written [1024];

  function automatic int eff_count(logic [COUNT_W-1:0] c);
    return (c > 1024) ? 1024 : int'(c);
  endfunction

  function automatic logic [31:0] stretch_step(logic [COUNT_W-1:0] ic,
                                               logic [COUNT_W-1:0] oc);
    longint num;
    longint den;
    if (eff_count(ic) < 2 || oc < COUNT_MIN) return '0;
    num = longint'(eff_count(ic) - 1) << FRAC_W;
    den = longint'(oc) - 1;
    return 32'(num / den);
  endfunction

  function automatic stretch_result_t stretch_fetch(logic [INDEX_W-1:0] j);
    stretch_result_t r;
    int              n;
    logic [31:0]     pos;
    int              ipart;
    longint          frac;
    int              a;
    int              b;
    longint          prod;
    n = eff_count(cur_in_count);
    r.sample = '0;
    if (n < 2 || cur_out_count < COUNT_MIN) begin
      r.status = STATUS_COUNT;
    end else if (int'(j) >= int'(cur_out_count)) begin
      r.status = STATUS_INDEX;
    end else begin
      r.status = STATUS_OK;
      pos = 32'(longint'(j) * longint'(cur_step));
      ipart = int'(pos[31:FRAC_W]);
      frac = longint'(pos[FRAC_W-1:0]);
      if (ipart >= n - 1 || int'(j) == int'(cur_out_count) - 1) begin
        r.sample = frame_shadow[n-1];
      end else begin
        a = int'(frame_shadow[ipart]);
        b = int'(frame_shadow[ipart+1]);
        prod = longint'(b - a) * frac;
        r.sample = SAMPLE_W'(a + int'(prod >>> FRAC_W));
      end
    end
    return r;
  endfunction

  // Accept tracking, model update and result checking
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  always @(posedge clk) begin
    stretch_result_t want;
    in_fire <= in_valid && !in_stall && !rst;
    out_fire <= out_valid && !out_stall && !rst;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_addr == CFG_IN_COUNT) cur_in_count = cfg_data;
        else cur_out_count = cfg_data;
        cur_step = stretch_step(cur_in_count, cur_out_count);
      end
      if (in_valid && !in_stall) begin
        if (opcode == OP_LOAD) frame_shadow[index] = sample_in;
        else fetch_results_q.push_back(stretch_fetch(index));
      end
      if (out_valid && !out_stall) begin
        if (fetch_results_q.size() == 0) begin
          $display("%0t: unexpected result: sample_out %0d status %0d", $time,
                   sample_out, status);
          errors++;
        end else begin
          want = fetch_results_q.pop_front();
          if (sample_out !== want.sample) begin
            $display("%0t: sample_out mismatch: expected %0d actual %0d", $time,
                     want.sample, sample_out);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, status);
            errors++;
          end
        end
      end
    end
  end

  // Input driver
  bit in_busy = 1'b0;
  bit in_burst = 1'b0;
  int in_gap = 0;

  always @(negedge clk) begin
    feed_item_t nxt;
    if (!rst) begin
      if (in_fire) begin
        in_busy = 1'b0;
        in_gap = in_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          nxt = feed_q.pop_front();
          opcode <= nxt.op;
          sample_in <= nxt.sample;
          index <= nxt.idx;
          in_valid <= 1'b1;
          in_busy = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure
  bit out_burst = 1'b0;
  int out_hold = 0;

  always @(negedge clk) begin
    if (out_fire) begin
      out_hold = out_burst ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
    end
    if (out_valid && out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_item(opcode_t op, logic [SAMPLE_W-1:0] s, logic [INDEX_W-1:0] j);
    feed_item_t it;
    it.op = op;
    it.sample = s;
    it.idx = j;
    feed_q.push_back(it);
    if (op == OP_LOAD) gen_written[j] = 1'b1;
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || in_busy || fetch_results_q.size() != 0)
      @(negedge clk);
  endtask

  // Every slot a fetch can read must hold data first
  task automatic fill_frame();
    int n;
    n = eff_count(gen_in);
    if (n >= 2 && gen_out >= COUNT_MIN) begin
      for (int i = 0; i < n; i++)
        if (!gen_written[i]) push_item(OP_LOAD, SAMPLE_W'($urandom), INDEX_W'(i));
    end
  endtask

  task automatic write_counts(logic [COUNT_W-1:0] ic, logic [COUNT_W-1:0] oc);
    wait_idle();
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_IN_COUNT;
    cfg_data <= ic;
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_OUT_COUNT;
    cfg_data <= oc;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_in = ic;
    gen_out = oc;
  endtask

  function automatic logic [COUNT_W-1:0] pick_count(int typical_hi);
    case ($urandom_range(0, 9))
      0: return COUNT_W'($urandom_range(0, 1));
      1: return COUNT_W'($urandom_range(typical_hi + 1, 1024));
      2: return COUNT_W'($urandom_range(1025, 2047));
      default: return COUNT_W'($urandom_range(2, typical_hi));
    endcase
  endfunction

  task automatic random_items(int count);
    int r;
    int hi;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        hi = (gen_out > 1024) ? 1024 : int'(gen_out);
        if (hi < 1) push_item(OP_FETCH, SAMPLE_W'($urandom), INDEX_W'($urandom));
        else if ($urandom_range(0, 6) == 0)
          push_item(OP_FETCH, SAMPLE_W'($urandom), INDEX_W'(hi - 1));
        else
          push_item(OP_FETCH, SAMPLE_W'($urandom), INDEX_W'($urandom_range(0, hi - 1)));
      end else if (r < 80) begin
        push_item(OP_FETCH, SAMPLE_W'($urandom), INDEX_W'($urandom));
      end else if (r < 95) begin
        hi = eff_count(gen_in);
        if (hi < 1) hi = 1024;
        push_item(OP_LOAD, SAMPLE_W'($urandom), INDEX_W'($urandom_range(0, hi - 1)));
      end else begin
        push_item(OP_LOAD, SAMPLE_W'($urandom), INDEX_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset counts: two in, two out
    push_item(OP_LOAD, 8'h00, 10'd0);
    push_item(OP_LOAD, 8'hFF, 10'd1);
    push_item(OP_LOAD, 8'hA5, 10'd1023);
    push_item(OP_FETCH, 8'h00, 10'd0);
    push_item(OP_FETCH, 8'hFF, 10'd1);
    push_item(OP_FETCH, 8'h00, 10'd2);
    push_item(OP_FETCH, 8'h00, 10'd1023);

    // counts below two
    write_counts(11'd0, 11'd5);
    push_item(OP_FETCH, 8'h00, 10'd0);
    write_counts(11'd1024, 11'd1);
    push_item(OP_FETCH, 8'h00, 10'd0);

    // in_count saturated, largest out_count
    write_counts(11'd2047, 11'd2047);
    fill_frame();
    push_item(OP_FETCH, 8'h00, 10'd0);
    push_item(OP_FETCH, 8'h00, 10'd511);
    push_item(OP_FETCH, 8'h00, 10'd1022);
    push_item(OP_FETCH, 8'h00, 10'd1023);

    // widest stretch and strongest shrink
    write_counts(11'd2, 11'd1024);
    push_item(OP_FETCH, 8'h00, 10'd0);
    push_item(OP_FETCH, 8'h00, 10'd1);
    push_item(OP_FETCH, 8'h00, 10'd511);
    push_item(OP_FETCH, 8'h00, 10'd1023);
    write_counts(11'd1024, 11'd2);
    push_item(OP_FETCH, 8'h00, 10'd0);
    push_item(OP_FETCH, 8'h00, 10'd1);
    push_item(OP_FETCH, 8'h00, 10'd2);

    for (int ph = 0; ph < 12; ph++) begin
      write_counts(pick_count(16), pick_count(64));
      fill_frame();
      random_items(80);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[linear_interp_frame_stretch] OK");
    else $display("[linear_interp_frame_stretch] ERROR");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[linear_interp_frame_stretch] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/lifs_pkg.sv
rtl/lifs_ctrl.sv
rtl/lifs_datapath.sv
rtl/linear_interp_frame_stretch.sv
tb/sv/tb_top.sv
